/* sv/ens_pkg.sv */
// ----------------------------------------------------------------------------
// ens_pkg: shared types and constants for the extent node search
// Status codes, header constants and the per-record evaluation bundle.
// ----------------------------------------------------------------------------
package ens_pkg;

  // Header and extent-length constants
  localparam logic [15:0] MAGIC_VALUE  = 16'hF30A;
  localparam logic [15:0] LEN_INIT_MAX = 16'h8000;

  localparam int unsigned BLOCK_W = 48;
  localparam int unsigned COUNT_W = 16;

  // Verdict codes carried on the result channel
  typedef enum logic [1:0] {
    STATUS_FOUND      = 2'd0,
    STATUS_NOT_MAPPED = 2'd1,
    STATUS_DESCEND    = 2'd2,
    STATUS_CORRUPT    = 2'd3
  } status_t;

  // Input record as held in the input register
  typedef struct packed {
    logic [31:0] target_block;
    logic        node_start;
    logic        node_end;
    logic [31:0] record_low;
    logic [31:0] record_middle;
    logic [31:0] record_high;
  } record_t;

  // Decoded view of one entry record, computed for both node kinds
  typedef struct packed {
    logic               leaf_hit;
    logic [BLOCK_W-1:0] leaf_block;
    logic               leaf_unwritten;
    logic               index_le;
    logic [BLOCK_W-1:0] child_block;
  } entry_eval_t;

  // Verdict for one node
  typedef struct packed {
    status_t            status;
    logic [BLOCK_W-1:0] physical_block;
    logic               unwritten;
  } verdict_t;

endpackage

/* sv/ens_in_if.sv */
// ----------------------------------------------------------------------------
// ens_in_if: record channel
// Valid/ready channel carrying one 12-byte node record per transaction.
// ----------------------------------------------------------------------------
interface ens_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] target_block;
  logic        node_start;
  logic        node_end;
  logic [31:0] record_low;
  logic [31:0] record_middle;
  logic [31:0] record_high;

  modport source (
    output valid, target_block, node_start, node_end,
           record_low, record_middle, record_high,
    input  ready
  );

  modport sink (
    input  valid, target_block, node_start, node_end,
           record_low, record_middle, record_high,
    output ready
  );
endinterface

/* sv/ens_out_if.sv */
// ----------------------------------------------------------------------------
// ens_out_if: verdict channel
// Valid/ready channel carrying one node verdict per transaction.
// ----------------------------------------------------------------------------
interface ens_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [47:0] physical_block;
  logic        unwritten;

  modport source (
    output valid, status, physical_block, unwritten,
    input  ready
  );

  modport sink (
    input  valid, status, physical_block, unwritten,
    output ready
  );
endinterface

/* sv/extent_node_search_top.sv */
// ----------------------------------------------------------------------------
// extent_node_search_top: extent tree node lookup
// Scans one extent node record by record and reports the mapping, the child
// node to descend to, not mapped, or a corrupt header.
//
//   channel   | direction | transaction
//   ----------+-----------+---------------------------------------------
//   records   | in        | one 12-byte node record plus target block
//   results   | out       | verdict on the node_end record
//
// Each record is registered, then evaluated and folded into the node state as
// it moves on; a node_end record loads its verdict into the result register at
// that same edge, so results is valid after the input and result registers.
// Throughput is one record per cycle unless a node_end record waits; the 33-bit
// range compare and 48-bit add set the critical path.
// Synchronous reset clears the node state and both valid flags.
// A node_end record waits in the input register only while a previous
// verdict is still held by results; other records never wait.
// ----------------------------------------------------------------------------
module extent_node_search_top (
  input  logic    clk,
  input  logic    rst,
  ens_in_if.sink  records,
  ens_out_if.source results
);

  logic                 in_valid;
  ens_pkg::record_t     in_rec;
  logic                 advance;
  ens_pkg::entry_eval_t eval;
  ens_pkg::verdict_t    verdict;
  logic                 out_valid;
  ens_pkg::verdict_t    out_data;

  // Held record moves on unless it is a node_end record and the result register holds a verdict not being taken
  assign advance = in_valid && (!in_rec.node_end || !out_valid || results.ready);
  assign records.ready = !in_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (records.ready) begin
      in_valid <= records.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (records.ready && records.valid) begin
      in_rec.target_block  <= records.target_block;
      in_rec.node_start    <= records.node_start;
      in_rec.node_end      <= records.node_end;
      in_rec.record_low    <= records.record_low;
      in_rec.record_middle <= records.record_middle;
      in_rec.record_high   <= records.record_high;
    end
  end

  ens_entry_eval u_eval (
    .rec  (in_rec),
    .eval (eval)
  );

  ens_node_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .take    (advance),
    .rec     (in_rec),
    .eval    (eval),
    .verdict (verdict)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && in_rec.node_end) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_rec.node_end) begin
      out_data <= verdict;
    end
  end

  assign results.valid          = out_valid;
  assign results.status         = out_data.status;
  assign results.physical_block = out_data.physical_block;
  assign results.unwritten      = out_data.unwritten;

`ifndef SYNTHESIS
  // a node_end record that moves on always yields a verdict next cycle
  a_end_gives_result: assert property (@(posedge clk) disable iff (rst)
    (advance && in_rec.node_end) |=> results.valid)
    else $error("node_end record produced no verdict");

  // a held node_end record blocks intake while the verdict is not taken
  a_stall_blocks_intake: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_rec.node_end && out_valid && !results.ready) |-> !records.ready)
    else $error("intake open while verdict stalled");

  // corrupt and not-mapped verdicts carry no block and no unwritten mark
  a_empty_verdict: assert property (@(posedge clk) disable iff (rst)
    (results.valid && (results.status == ens_pkg::STATUS_CORRUPT ||
                       results.status == ens_pkg::STATUS_NOT_MAPPED))
      |-> (results.physical_block == '0 && !results.unwritten))
    else $error("empty verdict carries data");

  // unwritten is only reported for a found extent
  a_unwritten_found: assert property (@(posedge clk) disable iff (rst)
    (results.valid && results.unwritten) |-> (results.status == ens_pkg::STATUS_FOUND))
    else $error("unwritten flag without found status");
`endif

endmodule

/* sv/ens_entry_eval.sv */
// ----------------------------------------------------------------------------
// ens_entry_eval: entry record decode
// Range compare and physical address for a leaf extent, and the key compare
// and child address for an index entry.
// ----------------------------------------------------------------------------
module ens_entry_eval (
  input  ens_pkg::record_t     rec,
  output ens_pkg::entry_eval_t eval
);

  logic [15:0] raw_len;
  logic        unw;
  logic [15:0] len;
  logic [32:0] range_end;
  logic [31:0] offset;
  logic [47:0] ext_start;

  // Extent length: above 0x8000 marks an unwritten extent
  always_comb begin
    raw_len = rec.record_middle[15:0];
    unw     = raw_len > ens_pkg::LEN_INIT_MAX;
    len     = unw ? (raw_len - ens_pkg::LEN_INIT_MAX) : raw_len;
  end

  // 33-bit range compare and 48-bit physical sum
  always_comb begin
    range_end = {1'b0, rec.record_low} + {17'd0, len};
    offset    = rec.target_block - rec.record_low;
    ext_start = {rec.record_middle[31:16], rec.record_high};

    eval.leaf_hit       = (rec.target_block >= rec.record_low) &&
                          ({1'b0, rec.target_block} < range_end);
    eval.leaf_block     = ext_start + {16'd0, offset};
    eval.leaf_unwritten = unw;
    eval.index_le       = rec.record_low <= rec.target_block;
    eval.child_block    = {rec.record_high[15:0], rec.record_middle};
  end

endmodule

/* sv/ens_node_ctrl.sv */
// ----------------------------------------------------------------------------
// ens_node_ctrl: per-node search state and verdict
// Tracks the header, the remaining entry count and the best match so far;
// forms the verdict from the state as updated by the current record.
// ----------------------------------------------------------------------------
module ens_node_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  take,
  input  ens_pkg::record_t      rec,
  input  ens_pkg::entry_eval_t  eval,
  output ens_pkg::verdict_t     verdict
);

  logic [ens_pkg::COUNT_W-1:0] entries_left, entries_left_next;
  logic                        leaf_node, leaf_node_next;
  logic                        magic_bad, magic_bad_next;
  logic                        match_found, match_found_next;
  logic [ens_pkg::BLOCK_W-1:0] match_block, match_block_next;
  logic                        match_unwritten, match_unwritten_next;
  logic                        pick_valid, pick_valid_next;
  logic [ens_pkg::BLOCK_W-1:0] pick_block, pick_block_next;
  logic                        scan_stopped, scan_stopped_next;
  logic                        entry_live;

  // Next state for the current record
  always_comb begin
    entries_left_next    = entries_left;
    leaf_node_next       = leaf_node;
    magic_bad_next       = magic_bad;
    match_found_next     = match_found;
    match_block_next     = match_block;
    match_unwritten_next = match_unwritten;
    pick_valid_next      = pick_valid;
    pick_block_next      = pick_block;
    scan_stopped_next    = scan_stopped;
    entry_live           = !rec.node_start && (entries_left != '0);

    if (rec.node_start) begin
      // header opens a fresh node
      magic_bad_next       = rec.record_low[15:0] != ens_pkg::MAGIC_VALUE;
      entries_left_next    = magic_bad_next ? '0 : rec.record_low[31:16];
      leaf_node_next       = rec.record_middle[31:16] == 16'd0;
      match_found_next     = 1'b0;
      match_block_next     = '0;
      match_unwritten_next = 1'b0;
      pick_valid_next      = 1'b0;
      pick_block_next      = '0;
      scan_stopped_next    = 1'b0;
    end else if (entry_live) begin
      entries_left_next = entries_left - {{(ens_pkg::COUNT_W-1){1'b0}}, 1'b1};
      if (leaf_node) begin
        // first covering extent wins
        if (!match_found && eval.leaf_hit) begin
          match_found_next     = 1'b1;
          match_block_next     = eval.leaf_block;
          match_unwritten_next = eval.leaf_unwritten;
        end
      end else if (!scan_stopped) begin
        // last index entry not above target; stop at first larger
        if (eval.index_le) begin
          pick_valid_next = 1'b1;
          pick_block_next = eval.child_block;
        end else begin
          scan_stopped_next = 1'b1;
        end
      end
    end

    if (rec.node_end) begin
      entries_left_next = '0;
    end
  end

  // Verdict from the updated state
  always_comb begin
    verdict.status         = ens_pkg::STATUS_NOT_MAPPED;
    verdict.physical_block = '0;
    verdict.unwritten      = 1'b0;
    if (magic_bad_next) begin
      verdict.status = ens_pkg::STATUS_CORRUPT;
    end else if (leaf_node_next) begin
      if (match_found_next) begin
        verdict.status         = ens_pkg::STATUS_FOUND;
        verdict.physical_block = match_block_next;
        verdict.unwritten      = match_unwritten_next;
      end
    end else if (pick_valid_next) begin
      verdict.status         = ens_pkg::STATUS_DESCEND;
      verdict.physical_block = pick_block_next;
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      entries_left    <= '0;
      leaf_node       <= 1'b0;
      magic_bad       <= 1'b0;
      match_found     <= 1'b0;
      match_block     <= '0;
      match_unwritten <= 1'b0;
      pick_valid      <= 1'b0;
      pick_block      <= '0;
      scan_stopped    <= 1'b0;
    end else if (take) begin
      entries_left    <= entries_left_next;
      leaf_node       <= leaf_node_next;
      magic_bad       <= magic_bad_next;
      match_found     <= match_found_next;
      match_block     <= match_block_next;
      match_unwritten <= match_unwritten_next;
      pick_valid      <= pick_valid_next;
      pick_block      <= pick_block_next;
      scan_stopped    <= scan_stopped_next;
    end
  end

endmodule
